// File: hdl/hgb_pkg.sv
package hgb_pkg;

   typedef struct packed {
      logic               func;
      logic [5:0]         weight_index;
      logic [15:0]        weight_value;
      logic signed [15:0] in_red;
      logic signed [15:0] in_green;
      logic signed [15:0] in_blue;
      logic signed [15:0] in_alpha;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_red;
      logic signed [15:0] out_green;
      logic signed [15:0] out_blue;
      logic signed [15:0] out_alpha;
      logic               row_last;
   } rsp_type;

   localparam logic       FUNC_WEIGHT = 1'b0;
   localparam logic [0:0] CSR_RADIUS  = 1'b0;
   localparam logic [0:0] CSR_STEP    = 1'b1;

   // accumulator: 16 x 16 signed product, wide enough for a sum over 255 taps
   localparam int ACC_W  = 41;
   localparam int WSUM_W = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAP,
      ST_DRAIN,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] mag;
      logic             neg;
      logic [WSUM_W-1:0] wsum;
   } div_req_type;

endpackage

// File: hdl/horizontal_gaussian_blur_rgba_unit.sv
// Horizontal normalized gaussian blur of a row-ordered RGBA stream. Load the
// 2*radius+1 weights (func=0) before a row, then send pixels (func=1) with
// row_end on the last one. radius and tap_step are sampled at the first pixel
// of every row. Output for column x appears once column x+radius is in;
// the rest of the row drains after row_end. Weights and the pixel window sit
// in synchronous memories (the pixel one single-port, the weight one with a
// separate write port); one tap is read per cycle and fed into four
// multiply-accumulates, then a shared bit-serial divider normalizes each
// channel by the used weight sum (per channel: load, the 42 quotient bits in
// turn, capture). A result visits up to 63 taps. The input is held off from a
// pixel transfer until its result and any flushed results are taken; a weight
// write holds nothing off. Every tap read lies in the current row, so the
// window never returns data from an earlier row.
module horizontal_gaussian_blur_rgba_unit #(
   parameter int MAX_RADIUS    = 31,
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hgb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hgb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [7:0]       csr_data
);
   localparam int NSLOTS = 2 * MAX_RADIUS + 1;
   localparam int SW     = $clog2(NSLOTS);
   localparam int CW     = $clog2(MAX_ROW_WIDTH);
   localparam int RW     = $clog2(MAX_RADIUS + 1);

   // config registers
   logic [4:0] radius_ff;
   logic [2:0] step_ff;

   // per row latches and column counters
   logic [RW-1:0] rrad_ff, rrad_in;
   logic [2:0]    rstep_ff, rstep_in;
   logic [CW-1:0] icol_ff, icol_in, ocol_ff, ocol_in, lastc_ff, lastc_in;
   logic          ends_ff, ends_in;

   hgb_pkg::state_type state_ff, state_in;

   // tap walk
   logic [CW:0]   nx_ff, nx_in, hi_ff, hi_in;
   logic [hgb_pkg::WSUM_W-1:0] wsum_ff, wsum_in;
   logic          rd_ff, rd_in;  // memory read in flight
   logic [1:0]    ch_ff, ch_in;
   logic          dgo_ff, dgo_in;  // divider start pending for ch_ff
   logic          dstart;
   logic [15:0]   res_ff [4];
   logic          mclear;

   // memories
   logic [15:0] wmem [NSLOTS];
   logic [63:0] pmem [256];
   logic [15:0] wq_ff;
   logic [63:0] pq_ff;

   logic          accept, pix;
   logic [CW:0]   lo, hi_c, xr;
   logic [CW:0]   idx_full;
   logic [SW-1:0] widx;
   logic [7:0]    paddr;
   logic          pwe;
   logic [CW:0]   step_ext;

   logic dbusy;
   logic signed [15:0] dq;
   logic signed [hgb_pkg::ACC_W-1:0] acc [4];
   logic go;
   logic start_pix_ff;
   logic walk;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         step_ff   <= 3'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            hgb_pkg::CSR_RADIUS: radius_ff <= csr_data[4:0];
            hgb_pkg::CSR_STEP:   step_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // pending flush columns are walked from idle without a new input
   assign go = (state_ff == hgb_pkg::ST_IDLE) && ends_ff && ocol_ff <= lastc_ff;

   // no new transfer while a pixel or a flush still owes work
   assign req_ready = (state_ff == hgb_pkg::ST_IDLE) && !start_pix_ff && !go;
   assign accept    = req_valid && req_ready;
   assign pix       = req_data.func != hgb_pkg::FUNC_WEIGHT;
   assign step_ext  = (CW + 1)'(rstep_ff);

   // window bounds for the column being produced
   always_comb begin
      xr   = (CW + 1)'(ocol_ff) + (CW + 1)'(rrad_ff);
      lo   = ((CW + 1)'(ocol_ff) >= (CW + 1)'(rrad_ff)) ?
             (CW + 1)'(ocol_ff) - (CW + 1)'(rrad_ff) : '0;
      hi_c = (xr < (CW + 1)'(lastc_ff)) ? xr : (CW + 1)'(lastc_ff);
   end

   // the tap index relative to -radius
   assign idx_full = nx_ff + (CW + 1)'(rrad_ff) - (CW + 1)'(ocol_ff);
   assign widx     = SW'(idx_full);
   assign pwe      = accept && pix;

   always_comb begin
      if (pwe) paddr = 8'(icol_ff);
      else     paddr = 8'(nx_ff);
   end

   // memories with a registered read
   always_ff @(posedge clock) begin
      if (accept && !pix && req_data.weight_index < 6'(NSLOTS))
         wmem[SW'(req_data.weight_index)] <= req_data.weight_value;
      wq_ff <= wmem[widx];
   end

   always_ff @(posedge clock) begin
      if (pwe)
         pmem[paddr] <= {req_data.in_red, req_data.in_green,
                         req_data.in_blue, req_data.in_alpha};
      pq_ff <= pmem[paddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hgb_pkg::ST_IDLE:  state_in = hgb_pkg::ST_IDLE;
         hgb_pkg::ST_TAP:   if (nx_ff + step_ext > hi_ff) state_in = hgb_pkg::ST_DRAIN;
         hgb_pkg::ST_DRAIN: state_in = hgb_pkg::ST_DIV;
         hgb_pkg::ST_DIV: begin
            if (!dgo_ff && !dbusy && ch_ff == 2'd3) state_in = hgb_pkg::ST_OUT;
         end
         hgb_pkg::ST_OUT:   if (rsp_ready) state_in = hgb_pkg::ST_IDLE;
         default:           state_in = hgb_pkg::ST_IDLE;
      endcase
   end

   // datapath and control
   always_comb begin
      rrad_in = rrad_ff; rstep_in = rstep_ff; icol_in = icol_ff; ocol_in = ocol_ff;
      lastc_in = lastc_ff; ends_in = ends_ff; nx_in = nx_ff; hi_in = hi_ff;
      wsum_in = wsum_ff; rd_in = 1'b0; ch_in = ch_ff; dgo_in = dgo_ff; dstart = 1'b0;
      unique case (state_ff)
         hgb_pkg::ST_IDLE: ;
         hgb_pkg::ST_TAP: begin
            rd_in = 1'b1;
            nx_in = nx_ff + step_ext;
         end
         hgb_pkg::ST_DRAIN: begin
            // last tap lands in the accumulators at this edge
            ch_in  = 2'd0;
            dgo_in = 1'b1;
         end
         hgb_pkg::ST_DIV: begin
            if (dgo_ff) begin
               dstart = 1'b1;
               dgo_in = 1'b0;
            end else if (!dbusy && ch_ff != 2'd3) begin
               ch_in  = ch_ff + 2'd1;
               dgo_in = 1'b1;
            end
         end
         hgb_pkg::ST_OUT: begin
            if (rsp_ready) begin
               ocol_in = ocol_ff + 1'b1;
               if (ends_ff && ocol_ff == lastc_ff) begin
                  ends_in = 1'b0;
                  icol_in = '0;
                  ocol_in = '0;
               end
            end
         end
         default: ;
      endcase
      if (rd_ff) wsum_in = wsum_ff + hgb_pkg::WSUM_W'(wq_ff);
      if (accept && pix) begin
         if (icol_ff == '0) begin
            rrad_in  = (radius_ff > 5'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_ff);
            rstep_in = (step_ff == 3'd0) ? 3'd1 : ((step_ff > 3'd4) ? 3'd4 : step_ff);
         end
         lastc_in = icol_ff;
         ends_in  = req_data.row_end || icol_ff == CW'(MAX_ROW_WIDTH - 1);
         if (!ends_in) icol_in = icol_ff + 1'b1;
      end
   end

   // entering a tap walk
   always_ff @(posedge clock) begin
      start_pix_ff <= reset ? 1'b0 : (accept && pix);
   end

   assign walk = (state_ff == hgb_pkg::ST_IDLE) && !accept &&
                 (go || (start_pix_ff && (CW + 1)'(lastc_ff) >= (CW + 1)'(rrad_ff)
                                      && ocol_ff <= lastc_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hgb_pkg::ST_IDLE;
         rd_ff    <= 1'b0;
         dgo_ff   <= 1'b0;
         icol_ff  <= '0;
         ocol_ff  <= '0;
         ends_ff  <= 1'b0;
         rrad_ff  <= '0;
         rstep_ff <= 3'd1;
         lastc_ff <= '0;
      end else begin
         state_ff <= walk ? hgb_pkg::ST_TAP : state_in;
         rd_ff    <= rd_in;
         dgo_ff   <= dgo_in;
         icol_ff  <= icol_in;
         ocol_ff  <= ocol_in;
         ends_ff  <= ends_in;
         rrad_ff  <= rrad_in;
         rstep_ff <= rstep_in;
         lastc_ff <= lastc_in;
      end
      nx_ff   <= walk ? lo : nx_in;
      hi_ff   <= walk ? hi_c : hi_in;
      wsum_ff <= walk ? '0 : wsum_in;
      ch_ff   <= ch_in;
   end

   assign mclear = walk;

   for (genvar c = 0; c < 4; c++) begin : g_mac
      hgb_mac u_mac (
         .clock (clock),
         .clear (mclear),
         .en    (rd_ff),
         .pix   ($signed(pq_ff[63 - 16*c -: 16])),
         .wgt   (wq_ff),
         .acc   (acc[c])
      );
   end

   // divider request per channel
   hgb_pkg::div_req_type dreq;
   logic [1:0] dch;
   assign dch = ch_ff;
   always_comb begin
      dreq.start = dstart;
      dreq.neg   = acc[dch][hgb_pkg::ACC_W-1];
      dreq.mag   = dreq.neg ? hgb_pkg::ACC_W'(-acc[dch]) : hgb_pkg::ACC_W'(acc[dch]);
      dreq.wsum  = wsum_ff;
   end

   hgb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (dreq),
      .busy    (dbusy),
      .quot    (dq)
   );

   // capture each channel when the divider goes idle
   logic [1:0] cap_ch_ff;
   logic       was_busy_ff;
   always_ff @(posedge clock) begin
      was_busy_ff <= reset ? 1'b0 : dbusy;
      if (dstart) cap_ch_ff <= dch;
      if (was_busy_ff && !dbusy) res_ff[cap_ch_ff] <= dq;
   end

   assign rsp_valid = (state_ff == hgb_pkg::ST_OUT);
   always_comb begin
      rsp_data.out_red   = res_ff[0];
      rsp_data.out_green = res_ff[1];
      rsp_data.out_blue  = res_ff[2];
      rsp_data.out_alpha = res_ff[3];
      rsp_data.row_last  = ends_ff && ocol_ff == lastc_ff;
   end
endmodule

// File: hdl/hgb_div.sv
// restoring divider, one quotient bit a cycle, rounding half away from zero
module hgb_div (
   input  logic                clock,
   input  logic                reset,
   input  hgb_pkg::div_req_type div_req,
   output logic                busy,
   output logic signed [15:0]  quot
);
   localparam int NW = hgb_pkg::ACC_W + 1;
   localparam int DW = hgb_pkg::WSUM_W + 1;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in, zero_ff, zero_in, busy_ff, busy_in;
   logic [DW:0]   trial;
   logic          big;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; zero_in = zero_ff; busy_in = busy_ff;
      trial = {rem_ff[DW-1:0], num_ff[NW-1]};
      if (div_req.start) begin
         num_in  = {div_req.mag, 1'b0} + NW'(div_req.wsum);
         den_in  = {div_req.wsum, 1'b0};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         neg_in  = div_req.neg;
         zero_in = (div_req.wsum == '0);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; zero_ff <= zero_in;
   end

   assign busy = busy_ff;

   always_comb begin
      big = (q_ff[NW-1:16] != '0);
      if (zero_ff) begin
         quot = '0;
      end else if (neg_ff) begin
         if (big || q_ff[15:0] > 16'd32768) quot = 16'sh8000;
         else quot = 16'(-$signed({1'b0, q_ff[15:0]}));
      end else begin
         if (big || q_ff[15]) quot = 16'sh7fff;
         else quot = $signed(q_ff[15:0]);
      end
   end
endmodule

// File: hdl/hgb_mac.sv
// weighted sum of one channel, one tap a cycle while en is high
module hgb_mac (
   input  logic                              clock,
   input  logic                              clear,
   input  logic                              en,
   input  logic signed [15:0]                pix,
   input  logic [15:0]                       wgt,
   output logic signed [hgb_pkg::ACC_W-1:0]  acc
);
   logic signed [hgb_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [32:0]               prod;

   always_comb begin
      prod   = pix * $signed({1'b0, wgt});
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      else if (en) acc_in = acc_ff + hgb_pkg::ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule
